>>> rtl/greedy_meshlet_builder_unit_assert.svh
// Assertion macros for the greedy meshlet builder.
// Used by the top level only; needs no package.
`ifndef GREEDY_MESHLET_BUILDER_UNIT_ASSERT_SVH
`define GREEDY_MESHLET_BUILDER_UNIT_ASSERT_SVH
`define GMB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GMB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/gmb_pkg.sv
// Package of the greedy meshlet builder: widths, limits and shared types.
// Used by every module of the block.
package gmb_pkg;
  localparam int unsigned VertexSpace  = 65536;
  localparam int unsigned MaxMembers   = 64;
  localparam int unsigned MaxTriangles = 126;
  localparam int unsigned VertW = 16;
  localparam int unsigned LimW  = 7;
  localparam logic [LimW-1:0] VertexLimitReset   = 7'd64;
  localparam logic [LimW-1:0] TriangleLimitReset = 7'd126;
  localparam logic CfgVertexLimit   = 1'b0;
  localparam logic CfgTriangleLimit = 1'b1;

  typedef struct packed {
    logic [VertW-1:0] va;
    logic [VertW-1:0] vb;
    logic [VertW-1:0] vc;
    logic             fin;
  } tri_t;
endpackage

>>> rtl/gmb_front.sv
// Front part of the greedy meshlet builder: accepts triangles into a short queue.
// Depends on gmb_pkg.
module gmb_front #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  gmb_pkg::tri_t in_tri_i,
  output logic          q_valid_o,
  input  logic          q_pop_i,
  output gmb_pkg::tri_t q_tri_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  gmb_pkg::tri_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0] cnt_q, cnt_d;
  logic push;

  assign in_stall_o = (cnt_q == (PtrW+1)'(Depth));
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = (cnt_q != '0);
  assign q_tri_o = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push) wr_d = (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
    if (q_pop_i) rd_d = (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_tri_i;
  end
endmodule

>>> rtl/gmb_back.sv
// Back part of the greedy meshlet builder: slot map memory, member list and sequencer.
// Depends on gmb_pkg.
module gmb_back #(
  parameter int unsigned VertexSpace  = gmb_pkg::VertexSpace,
  parameter int unsigned MaxMembers   = gmb_pkg::MaxMembers,
  parameter int unsigned MaxTriangles = gmb_pkg::MaxTriangles
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  output logic                     q_pop_o,
  input  gmb_pkg::tri_t            q_tri_i,
  input  logic [gmb_pkg::LimW-1:0] vlim_i,
  input  logic [gmb_pkg::LimW-1:0] tlim_i,
  output logic                     busy_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     starts_o,
  output logic                     closes_o,
  output logic [6:0]               slot_o,
  output logic [5:0]               la_o,
  output logic [5:0]               lb_o,
  output logic [5:0]               lc_o,
  output logic [1:0]               nnew_o,
  output logic [15:0]              nv0_o,
  output logic [15:0]              nv1_o,
  output logic [15:0]              nv2_o
);
  localparam int unsigned AW = $clog2(VertexSpace);
  localparam int unsigned SW = $clog2(MaxMembers);
  localparam int unsigned MW = $clog2(MaxMembers + 1);
  localparam int unsigned TW = $clog2(MaxTriangles + 1);
  localparam int unsigned EW = SW + 1;

  typedef enum logic [6:0] {
    StInit  = 7'b0000001,
    StIdle  = 7'b0000010,
    StChk   = 7'b0000100,
    StClr   = 7'b0001000,
    StPlRd  = 7'b0010000,
    StPlace = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  // A map entry is a valid bit above the local slot.
  logic [EW-1:0] map_q [VertexSpace];
  logic [gmb_pkg::VertW-1:0] list_q [MaxMembers];
  logic [EW-1:0] rd_data_q;
  logic [gmb_pkg::VertW-1:0] lst_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;
  logic wr_en, lst_wr_en;

  state_e st_q, st_d;
  logic [AW-1:0] init_q, init_d;
  logic [MW-1:0] mcnt_q, mcnt_d, clr_q, clr_d;
  logic clr_pend_q, clr_pend_d;
  logic [TW-1:0] tcnt_q, tcnt_d;
  logic [1:0] k_q, k_d;
  logic [1:0] hit_q, hit_d;
  logic ov_q, ov_d;
  logic ovld_q, ovld_d;
  gmb_pkg::tri_t t_q, t_d;
  logic [SW-1:0] loc_q [3];
  logic [SW-1:0] loc_d [3];
  logic [15:0] nv_q [3];
  logic [15:0] nv_d [3];
  logic [1:0] nn_q, nn_d;
  logic starts_q, starts_d;
  logic [TW-1:0] slot_q, slot_d;
  logic [MW-1:0] vl;
  logic [TW-1:0] tl;
  logic [AW-1:0] cur_v;
  logic [MW+1:0] need;
  logic [SW-1:0] ns;
  logic entry_ok;
  logic take;

  always_comb begin
    if (vlim_i < 7'd3) vl = MW'(3);
    else if (8'(vlim_i) > 8'(MaxMembers)) vl = MW'(MaxMembers);
    else vl = MW'(vlim_i);
    if (tlim_i == '0) tl = TW'(1);
    else if (8'(tlim_i) > 8'(MaxTriangles)) tl = TW'(MaxTriangles);
    else tl = TW'(tlim_i);
  end

  always_comb begin
    case (k_q)
      2'd0:    cur_v = AW'(t_q.va);
      2'd1:    cur_v = AW'(t_q.vb);
      default: cur_v = AW'(t_q.vc);
    endcase
  end

  assign entry_ok = rd_data_q[EW-1];
  assign ns = (mcnt_q >= MW'(MaxMembers)) ? SW'(MaxMembers - 1) : mcnt_q[SW-1:0];
  assign need = (MW+2)'(mcnt_q) + (MW+2)'(!hit_q[0]) + (MW+2)'(!hit_q[1])
              + (MW+2)'(!entry_ok);
  assign take = q_valid_i && (!ovld_q || !out_stall_i);

  always_comb begin
    st_d = st_q;
    init_d = init_q;
    mcnt_d = mcnt_q;
    clr_d = clr_q;
    clr_pend_d = 1'b0;
    tcnt_d = tcnt_q;
    k_d = k_q;
    hit_d = hit_q;
    ov_d = ov_q;
    ovld_d = ovld_q;
    t_d = t_q;
    loc_d = loc_q;
    nv_d = nv_q;
    nn_d = nn_q;
    starts_d = starts_q;
    slot_d = slot_q;
    q_pop_o = 1'b0;
    rd_addr = cur_v;
    wr_en = 1'b0;
    wr_addr = cur_v;
    wr_data = '0;
    lst_wr_en = 1'b0;
    if (ovld_q && !out_stall_i) ovld_d = 1'b0;
    case (st_q)
      StInit: begin
        wr_en = 1'b1;
        wr_addr = init_q;
        init_d = init_q + 1'b1;
        if (init_q == AW'(VertexSpace - 1)) st_d = StIdle;
      end
      StIdle: begin
        if (take) begin
          q_pop_o = 1'b1;
          t_d = q_tri_i;
          k_d = 2'd0;
          nn_d = 2'd0;
          nv_d[0] = '0;
          nv_d[1] = '0;
          nv_d[2] = '0;
          st_d = StChk;
        end
      end
      StChk: begin
        if (k_q == 2'd1) hit_d[0] = entry_ok;
        if (k_q == 2'd2) hit_d[1] = entry_ok;
        if (k_q == 2'd3) begin
          k_d = 2'd0;
          if (need > (MW+2)'(vl) || tcnt_q >= tl) begin
            ov_d = 1'b1;
            clr_d = '0;
            st_d = StClr;
          end else begin
            st_d = StPlRd;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      StClr: begin
        if (clr_pend_q) begin
          wr_en = 1'b1;
          wr_addr = AW'(lst_q);
        end
        if (clr_q != mcnt_q) begin
          clr_d = clr_q + 1'b1;
          clr_pend_d = 1'b1;
        end else begin
          mcnt_d = '0;
          tcnt_d = '0;
          ov_d = 1'b0;
          k_d = 2'd0;
          st_d = ov_q ? StPlRd : StIdle;
        end
      end
      StPlRd: st_d = StPlace;
      StPlace: begin
        if (entry_ok) begin
          loc_d[k_q] = rd_data_q[SW-1:0];
        end else begin
          loc_d[k_q] = ns;
          wr_en = 1'b1;
          wr_data = {1'b1, ns};
          lst_wr_en = 1'b1;
          nv_d[nn_q] = 16'(cur_v);
          nn_d = nn_q + 1'b1;
          if (mcnt_q < MW'(MaxMembers)) mcnt_d = mcnt_q + 1'b1;
        end
        if (k_q == 2'd2) begin
          k_d = 2'd0;
          st_d = StOut;
        end else begin
          k_d = k_q + 1'b1;
          st_d = StPlRd;
        end
      end
      StOut: begin
        starts_d = (tcnt_q == '0);
        slot_d = tcnt_q;
        tcnt_d = tcnt_q + 1'b1;
        ovld_d = 1'b1;
        clr_d = '0;
        st_d = t_q.fin ? StClr : StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StInit;
      init_q <= '0;
      mcnt_q <= '0;
      clr_q <= '0;
      clr_pend_q <= 1'b0;
      tcnt_q <= '0;
      k_q <= '0;
      ov_q <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      init_q <= init_d;
      mcnt_q <= mcnt_d;
      clr_q <= clr_d;
      clr_pend_q <= clr_pend_d;
      tcnt_q <= tcnt_d;
      k_q <= k_d;
      ov_q <= ov_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    hit_q <= hit_d;
    loc_q <= loc_d;
    nv_q <= nv_d;
    nn_q <= nn_d;
    starts_q <= starts_d;
    slot_q <= slot_d;
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= map_q[rd_addr];
    if (wr_en) map_q[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    lst_q <= list_q[clr_q[SW-1:0]];
    if (lst_wr_en) list_q[ns] <= 16'(cur_v);
  end

  assign busy_o = (st_q != StIdle) || ovld_q;
  assign out_valid_o = ovld_q;
  assign starts_o = starts_q;
  assign closes_o = t_q.fin;
  assign slot_o = 7'(slot_q);
  assign la_o = 6'(loc_q[0]);
  assign lb_o = 6'(loc_q[1]);
  assign lc_o = 6'(loc_q[2]);
  assign nnew_o = nn_q;
  assign nv0_o = nv_q[0];
  assign nv1_o = nv_q[1];
  assign nv2_o = nv_q[2];
endmodule

>>> rtl/greedy_meshlet_builder_unit.sv
// Greedy meshlet builder: takes one triangle per transaction as three global vertex indices,
// packs the stream into meshlets bounded by the programmable vertex and triangle limits and
// returns one result transaction per triangle. Depends on gmb_pkg, gmb_front, gmb_back and the
// assertion header. After reset the slot map is cleared one entry per cycle before the first
// triangle is taken; the two-entry input queue fills meanwhile. In the back part each triangle
// is then taken from the queue, its three corners are looked up in the slot map, each corner
// is placed in turn, and the result is issued. A meshlet is closed by clearing the map entry of
// each member, before the triangle when a limit overflows and after the result for a final
// triangle. A result that is not yet taken holds back the next triangle. The user must write
// the limits only while no triangle is in flight; the block itself does not enforce it.
`include "greedy_meshlet_builder_unit_assert.svh"
module greedy_meshlet_builder_unit #(
  parameter int unsigned VertexSpace  = gmb_pkg::VertexSpace,
  parameter int unsigned MaxMembers   = gmb_pkg::MaxMembers,
  parameter int unsigned MaxTriangles = gmb_pkg::MaxTriangles
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] vertex_a_i,
  input  logic [15:0] vertex_b_i,
  input  logic [15:0] vertex_c_i,
  input  logic        final_triangle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        starts_meshlet_o,
  output logic        closes_meshlet_o,
  output logic [6:0]  triangle_slot_o,
  output logic [5:0]  local_a_o,
  output logic [5:0]  local_b_o,
  output logic [5:0]  local_c_o,
  output logic [1:0]  new_vertex_count_o,
  output logic [15:0] new_vertex_0_o,
  output logic [15:0] new_vertex_1_o,
  output logic [15:0] new_vertex_2_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i
);
  logic [6:0] vlim_q, tlim_q;
  gmb_pkg::tri_t in_tri, q_tri;
  logic q_valid, q_pop, busy;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlim_q <= gmb_pkg::VertexLimitReset;
      tlim_q <= gmb_pkg::TriangleLimitReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == gmb_pkg::CfgVertexLimit) vlim_q <= cfg_data_i;
      else tlim_q <= cfg_data_i;
    end
  end

  assign in_tri = '{va: vertex_a_i, vb: vertex_b_i, vc: vertex_c_i, fin: final_triangle_i};

  gmb_front #(.Depth(2)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_tri_i(in_tri),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_tri_o(q_tri)
  );

  gmb_back #(.VertexSpace(VertexSpace), .MaxMembers(MaxMembers),
             .MaxTriangles(MaxTriangles)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_tri_i(q_tri),
    .vlim_i(vlim_q), .tlim_i(tlim_q), .busy_o(busy),
    .out_valid_o, .out_stall_i, .starts_o(starts_meshlet_o),
    .closes_o(closes_meshlet_o), .slot_o(triangle_slot_o), .la_o(local_a_o),
    .lb_o(local_b_o), .lc_o(local_c_o), .nnew_o(new_vertex_count_o),
    .nv0_o(new_vertex_0_o), .nv1_o(new_vertex_1_o), .nv2_o(new_vertex_2_o)
  );

  `GMB_ASSERT_IMPL(a_pop_needs_item, clk_i, rst_ni, q_pop, q_valid)
  `GMB_ASSERT_IMPL(a_out_while_busy, clk_i, rst_ni, out_valid_o, busy)
  `GMB_ASSERT_NEXT(a_out_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
endmodule

>>> verif/tb_greedy_meshlet_builder_unit.sv
// Self-checking testbench for greedy_meshlet_builder_unit: directed table, then random
// triangle streams under several vertex and triangle limits, checked by a built-in predictor.
// Depends on gmb_pkg and the RTL of the block only.
module tb_greedy_meshlet_builder_unit;
  typedef struct packed {
    bit        starts;
    bit        closes;
    bit [6:0]  slot;
    bit [5:0]  loc_a;
    bit [5:0]  loc_b;
    bit [5:0]  loc_c;
    bit [1:0]  n_new;
    bit [15:0] new0;
    bit [15:0] new1;
    bit [15:0] new2;
  } tri_res_t;

  typedef struct {
    bit [15:0] va;
    bit [15:0] vb;
    bit [15:0] vc;
    bit        fin;
    bit        typed;
    tri_res_t  res;
  } dir_row_t;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o;
  logic [15:0] vertex_a_i, vertex_b_i, vertex_c_i;
  logic        final_triangle_i;
  logic        out_valid_o, out_stall_i;
  logic        starts_meshlet_o, closes_meshlet_o;
  logic [6:0]  triangle_slot_o;
  logic [5:0]  local_a_o, local_b_o, local_c_o;
  logic [1:0]  new_vertex_count_o;
  logic [15:0] new_vertex_0_o, new_vertex_1_o, new_vertex_2_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic        cfg_index_i;
  logic [6:0]  cfg_data_i;

  greedy_meshlet_builder_unit dut (.*);

  bit        map_valid [gmb_pkg::VertexSpace];
  bit [5:0]  map_slot  [gmb_pkg::VertexSpace];
  bit [15:0] members   [gmb_pkg::MaxMembers];
  int unsigned member_cnt, tri_cnt;
  bit [6:0]  vert_limit_reg, tri_limit_reg;

  tri_res_t  pending_tris[$];
  int        mismatches;
  int        results_seen;
  int        send_idle_pct, recv_stall_pct;
  int        hold_left;
  bit        hold_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void close_current();
    for (int j = 0; j < member_cnt && j < gmb_pkg::MaxMembers; j++)
      map_valid[members[j]] = 1'b0;
    member_cnt = 0;
    tri_cnt = 0;
  endfunction

  function automatic bit [5:0] place_corner(input bit [15:0] v, inout tri_res_t r);
    int unsigned s;
    if (!map_valid[v]) begin
      s = (member_cnt >= gmb_pkg::MaxMembers) ? gmb_pkg::MaxMembers - 1 : member_cnt;
      map_slot[v] = s[5:0];
      map_valid[v] = 1'b1;
      members[s] = v;
      if (member_cnt < gmb_pkg::MaxMembers) member_cnt++;
      case (r.n_new)
        2'd0: r.new0 = v;
        2'd1: r.new1 = v;
        default: r.new2 = v;
      endcase
      r.n_new = r.n_new + 2'd1;
    end
    return map_slot[v];
  endfunction

  function automatic tri_res_t pack_triangle(input bit [15:0] va, vb, vc, input bit fin);
    tri_res_t r;
    int unsigned vlim, tlim, need;
    r = '0;
    vlim = vert_limit_reg;
    tlim = tri_limit_reg;
    if (vlim < 3) vlim = 3;
    if (vlim > gmb_pkg::MaxMembers) vlim = gmb_pkg::MaxMembers;
    if (tlim < 1) tlim = 1;
    if (tlim > gmb_pkg::MaxTriangles) tlim = gmb_pkg::MaxTriangles;
    need = member_cnt + !map_valid[va] + !map_valid[vb] + !map_valid[vc];
    if (need > vlim || tri_cnt >= tlim) close_current();
    r.starts = (tri_cnt == 0);
    r.loc_a = place_corner(va, r);
    r.loc_b = place_corner(vb, r);
    r.loc_c = place_corner(vc, r);
    r.slot = tri_cnt[6:0];
    tri_cnt++;
    r.closes = fin;
    if (fin) close_current();
    return r;
  endfunction

  task automatic send_triangle(input bit [15:0] va, vb, vc, input bit fin,
                               input bit typed, input tri_res_t typed_res);
    tri_res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vertex_a_i <= va;
    vertex_b_i <= vb;
    vertex_c_i <= vc;
    final_triangle_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = pack_triangle(va, vb, vc, fin);
    pending_tris.insert(pending_tris.size(), typed ? typed_res : r);
  endtask

  task automatic write_limit(input logic idx, input bit [6:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == gmb_pkg::CfgVertexLimit) vert_limit_reg = val;
    else tri_limit_reg = val;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_tris.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (!hold_done && results_seen >= 150) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    tri_res_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{starts_meshlet_o, closes_meshlet_o, triangle_slot_o, local_a_o, local_b_o,
              local_c_o, new_vertex_count_o, new_vertex_0_o, new_vertex_1_o, new_vertex_2_o};
      results_seen <= results_seen + 1;
      if (pending_tris.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected transaction: %p", got);
      end else begin
        want = pending_tris.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  initial begin
    dir_row_t dir_rows[8];
    bit [6:0] vl_set[6] = '{7'd64, 7'd3, 7'd0, 7'd127, 7'd5, 7'd40};
    bit [6:0] tl_set[6] = '{7'd126, 7'd1, 7'd0, 7'd127, 7'd3, 7'd9};
    bit [15:0] base, v[3];
    int span;

    dir_rows[0] = '{16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b1,
                    '{1'b1, 1'b0, 7'd0, 6'd0, 6'd1, 6'd0, 2'd2, 16'h0000, 16'hFFFF, 16'h0}};
    dir_rows[1] = '{16'h5555, 16'hAAAA, 16'hFFFF, 1'b0, 1'b0, '0};
    dir_rows[2] = '{16'h0001, 16'h0001, 16'h0001, 1'b0, 1'b0, '0};
    dir_rows[3] = '{16'h0000, 16'h5555, 16'h0002, 1'b0, 1'b0, '0};
    dir_rows[4] = '{16'h8000, 16'h7FFF, 16'h0003, 1'b1, 1'b0, '0};
    dir_rows[5] = '{16'h0007, 16'h0008, 16'h0009, 1'b1, 1'b1,
                    '{1'b1, 1'b1, 7'd0, 6'd0, 6'd1, 6'd2, 2'd3, 16'h7, 16'h8, 16'h9}};
    dir_rows[6] = '{16'h1234, 16'h4321, 16'h1234, 1'b0, 1'b0, '0};
    dir_rows[7] = '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 1'b0, '0};

    map_valid = '{default: 1'b0};
    map_slot = '{default: 6'd0};
    members = '{default: 16'd0};
    member_cnt = 0;
    tri_cnt = 0;
    vert_limit_reg = gmb_pkg::VertexLimitReset;
    tri_limit_reg = gmb_pkg::TriangleLimitReset;
    mismatches = 0;
    results_seen = 0;
    hold_left = 0;
    hold_done = 1'b0;
    send_idle_pct = 12;
    recv_stall_pct = 75;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    vertex_a_i = '0;
    vertex_b_i = '0;
    vertex_c_i = '0;
    final_triangle_i = 1'b0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = gmb_pkg::CfgVertexLimit;
    cfg_data_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      send_triangle(dir_rows[i].va, dir_rows[i].vb, dir_rows[i].vc, dir_rows[i].fin,
                    dir_rows[i].typed, dir_rows[i].res);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 12; recv_stall_pct = 75; end
        1: begin send_idle_pct = 75; recv_stall_pct = 12; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      write_limit(gmb_pkg::CfgVertexLimit, vl_set[ph]);
      write_limit(gmb_pkg::CfgTriangleLimit, tl_set[ph]);
      base = 16'($urandom_range(0, 65535));
      span = $urandom_range(4, 80);
      for (int n = 0; n < 240; n++) begin
        for (int k = 0; k < 3; k++) begin
          if ($urandom_range(9) == 0) v[k] = 16'($urandom_range(0, 65535));
          else v[k] = 16'(base + $urandom_range(0, span));
        end
        if ($urandom_range(49) == 0) begin
          base = 16'($urandom_range(0, 65535));
          span = $urandom_range(4, 80);
        end
        send_triangle(v[0], v[1], v[2], $urandom_range(24) == 0, 1'b0, '0);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
